/* hw/rtl/phh_pkg.sv */
// Shared types and constants for the pulse-height histogram engine.
`timescale 1ns / 1ps
package phh_pkg;

   localparam int BIN_COUNT_DEF   = 4096;
   localparam int COUNT_WIDTH_DEF = 32;
   localparam int CODE_W          = 16;
   localparam int STAT_W          = 32;
   localparam int SUM_W           = 48;

   localparam logic [CODE_W-1:0] FULL_SCALE_CODE = 16'hFFFF;
   localparam logic [1:0]        REG_HIST_EN     = 2'd0;

   typedef enum logic [1:0] {
      CMD_SAMPLE = 2'd0,
      CMD_CLEAR  = 2'd1,
      CMD_READ   = 2'd2,
      CMD_NONE   = 2'd3
   } cmd_type;

   typedef enum logic [1:0] {
      BK_SWEEP = 2'd0,
      BK_IDLE  = 2'd1,
      BK_EXEC  = 2'd2
   } back_state_type;

   typedef struct packed {
      cmd_type           cmd;
      logic [CODE_W-1:0] sample_code;
      logic [11:0]       bin_index;
   } req_type;

   typedef struct packed {
      logic [STAT_W-1:0] bin_count;
      logic [STAT_W-1:0] sample_total;
      logic [SUM_W-1:0]  code_sum;
      logic [CODE_W-1:0] peak_code;
      logic [STAT_W-1:0] full_scale_count;
   } rsp_type;

endpackage

/* hw/rtl/phh_front.sv */
// Front end: accepts requests, maps codes to bins and queues decoded operations.
`timescale 1ns / 1ps
module phh_front import phh_pkg::*; #(
   parameter int  BIN_COUNT = BIN_COUNT_DEF,
   localparam int ADDR_W    = $clog2(BIN_COUNT)
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              push,
   output logic              full,
   input  req_type           req_payload,
   input  logic              init_busy,
   output logic              op_valid,
   output cmd_type           op_cmd,
   output logic [ADDR_W-1:0] op_addr,
   output logic              op_rd_ok,
   output logic [CODE_W-1:0] op_code,
   input  logic              op_take
);

   localparam int QD     = 4;
   localparam int QPW    = $clog2(QD);
   localparam int PROD_W = CODE_W + 17;
   localparam logic [PROD_W-1:0] BIN_SCALE = PROD_W'(BIN_COUNT);

   typedef struct packed {
      cmd_type           cmd;
      logic [ADDR_W-1:0] addr;
      logic              rd_ok;
      logic [CODE_W-1:0] code;
   } op_type;

   op_type           q_ff [QD];
   logic [QPW-1:0]   wr_ff, wr_in, rd_ff, rd_in;
   logic [QPW:0]     cnt_ff, cnt_in;
   logic [PROD_W-1:0] prod;
   logic [31:0]      idx_wide;
   op_type           op_new, op_head;
   logic             accept;

   always_comb begin
      prod        = PROD_W'(req_payload.sample_code) * BIN_SCALE;
      idx_wide    = 32'(req_payload.bin_index);
      op_new.cmd  = req_payload.cmd;
      op_new.code = req_payload.sample_code;
      op_new.rd_ok = idx_wide < 32'(BIN_COUNT);
      if (req_payload.cmd == CMD_READ) begin
         op_new.addr = idx_wide[ADDR_W-1:0];
      end else begin
         op_new.addr = prod[CODE_W +: ADDR_W];
      end
   end

   assign full   = (cnt_ff == (QPW+1)'(QD)) || init_busy;
   assign accept = push && !full;

   always_comb begin
      wr_in  = wr_ff;
      rd_in  = rd_ff;
      cnt_in = cnt_ff;
      if (accept) begin
         wr_in = wr_ff + 1'b1;
      end
      if (op_take) begin
         rd_in = rd_ff + 1'b1;
      end
      if (accept && !op_take) begin
         cnt_in = cnt_ff + 1'b1;
      end else if (!accept && op_take) begin
         cnt_in = cnt_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff  <= '0;
         rd_ff  <= '0;
         cnt_ff <= '0;
      end else begin
         wr_ff  <= wr_in;
         rd_ff  <= rd_in;
         cnt_ff <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         q_ff[wr_ff] <= op_new;
      end
   end

   assign op_head  = q_ff[rd_ff];
   assign op_valid = cnt_ff != '0;
   assign op_cmd   = op_head.cmd;
   assign op_addr  = op_head.addr;
   assign op_rd_ok = op_head.rd_ok;
   assign op_code  = op_head.code;

endmodule

/* hw/rtl/phh_back.sv */
// Back end: bin memory read-modify-write, clear sweep, statistics and result queue.
`timescale 1ns / 1ps
module phh_back import phh_pkg::*; #(
   parameter int  BIN_COUNT   = BIN_COUNT_DEF,
   parameter int  COUNT_WIDTH = COUNT_WIDTH_DEF,
   localparam int ADDR_W      = $clog2(BIN_COUNT)
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              hist_en,
   input  logic              op_valid,
   input  cmd_type           op_cmd,
   input  logic [ADDR_W-1:0] op_addr,
   input  logic              op_rd_ok,
   input  logic [CODE_W-1:0] op_code,
   output logic              op_take,
   output logic              init_busy,
   output logic              rsp_empty,
   input  logic              rsp_pop,
   output rsp_type           rsp_data
);

   localparam logic [ADDR_W-1:0] LAST_ADDR = ADDR_W'(BIN_COUNT - 1);

   back_state_type    state_ff, state_in;
   logic [ADDR_W-1:0] addr_ff, addr_in;
   cmd_type           cmd_ff, cmd_in;
   logic              rd_ok_ff, rd_ok_in;
   logic              incr_ff, incr_in;
   logic              silent_ff, silent_in;
   logic [SUM_W-1:0]  sum_ff, sum_in;
   logic [STAT_W-1:0] total_ff, total_in;
   logic [CODE_W-1:0] peak_ff, peak_in;
   logic [STAT_W-1:0] fs_ff, fs_in;

   logic [COUNT_WIDTH-1:0] mem [BIN_COUNT];
   logic [COUNT_WIDTH-1:0] mem_q_ff;
   logic [COUNT_WIDTH-1:0] mem_wdata;
   logic                   mem_we;
   logic [63:0]            bin_wide;

   rsp_type    oq_ff [2];
   logic       oq_wr_ff, oq_rd_ff;
   logic [1:0] oq_cnt_ff;
   logic       push, pop;
   rsp_type    rsp_word;

   assign bin_wide  = 64'(mem_q_ff);
   assign init_busy = (state_ff == BK_SWEEP) && silent_ff;

   always_comb begin
      state_in  = state_ff;
      addr_in   = addr_ff;
      cmd_in    = cmd_ff;
      rd_ok_in  = rd_ok_ff;
      incr_in   = incr_ff;
      silent_in = silent_ff;
      sum_in    = sum_ff;
      total_in  = total_ff;
      peak_in   = peak_ff;
      fs_in     = fs_ff;
      op_take   = 1'b0;
      mem_we    = 1'b0;
      mem_wdata = '0;
      push      = 1'b0;
      rsp_word.bin_count        = '0;
      rsp_word.sample_total     = total_ff;
      rsp_word.code_sum         = sum_ff;
      rsp_word.peak_code        = peak_ff;
      rsp_word.full_scale_count = fs_ff;
      unique case (state_ff)
         BK_SWEEP: begin
            mem_we = 1'b1;
            if (addr_ff == LAST_ADDR) begin
               state_in  = BK_IDLE;
               push      = !silent_ff;
               silent_in = 1'b0;
            end else begin
               addr_in = addr_ff + 1'b1;
            end
         end
         BK_IDLE: begin
            if (op_valid && oq_cnt_ff != 2'd2) begin
               op_take  = 1'b1;
               cmd_in   = op_cmd;
               addr_in  = op_addr;
               rd_ok_in = op_rd_ok;
               incr_in  = 1'b0;
               state_in = BK_EXEC;
               unique case (op_cmd)
                  CMD_SAMPLE: begin
                     incr_in  = hist_en;
                     sum_in   = sum_ff + SUM_W'(op_code);
                     total_in = total_ff + 1'b1;
                     if (op_code == FULL_SCALE_CODE) begin
                        fs_in = fs_ff + 1'b1;
                     end
                     if (op_code > peak_ff) begin
                        peak_in = op_code;
                     end
                  end
                  CMD_CLEAR: begin
                     sum_in   = '0;
                     total_in = '0;
                     peak_in  = '0;
                     fs_in    = '0;
                     addr_in  = '0;
                     state_in = BK_SWEEP;
                  end
                  default: ;
               endcase
            end
         end
         BK_EXEC: begin
            state_in = BK_IDLE;
            push     = 1'b1;
            if (cmd_ff == CMD_READ && rd_ok_ff) begin
               rsp_word.bin_count = bin_wide[31:0];
            end
            if (incr_ff) begin
               mem_we    = 1'b1;
               mem_wdata = mem_q_ff + COUNT_WIDTH'(1);
            end
         end
         default: begin
            state_in = BK_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= BK_SWEEP;
         addr_ff   <= '0;
         silent_ff <= 1'b1;
         incr_ff   <= 1'b0;
         sum_ff    <= '0;
         total_ff  <= '0;
         peak_ff   <= '0;
         fs_ff     <= '0;
      end else begin
         state_ff  <= state_in;
         addr_ff   <= addr_in;
         silent_ff <= silent_in;
         incr_ff   <= incr_in;
         sum_ff    <= sum_in;
         total_ff  <= total_in;
         peak_ff   <= peak_in;
         fs_ff     <= fs_in;
      end
   end

   always_ff @(posedge clock) begin
      cmd_ff   <= cmd_in;
      rd_ok_ff <= rd_ok_in;
   end

   always_ff @(posedge clock) begin
      if (mem_we) begin
         mem[addr_ff] <= mem_wdata;
      end
      mem_q_ff <= mem[op_addr];
   end

   assign pop       = rsp_pop && !rsp_empty;
   assign rsp_empty = oq_cnt_ff == 2'd0;
   assign rsp_data  = oq_ff[oq_rd_ff];

   always_ff @(posedge clock) begin
      if (reset) begin
         oq_wr_ff  <= 1'b0;
         oq_rd_ff  <= 1'b0;
         oq_cnt_ff <= 2'd0;
      end else begin
         if (push) begin
            oq_wr_ff <= !oq_wr_ff;
         end
         if (pop) begin
            oq_rd_ff <= !oq_rd_ff;
         end
         if (push && !pop) begin
            oq_cnt_ff <= oq_cnt_ff + 1'b1;
         end else if (!push && pop) begin
            oq_cnt_ff <= oq_cnt_ff - 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         oq_ff[oq_wr_ff] <= rsp_word;
      end
   end

endmodule

/* hw/rtl/pulse_height_histogram_engine.sv */
// Top level of the pulse-height histogram engine: front end, back end and CSR.
// Samples and reads pass the front queue, the back end and the result queue.
// The back end takes a new sample or read only after the bin memory read-modify-write.
// During a clear the back end sweeps one bin per cycle.
// Reset: synchronous; afterwards a clearing pass over all bins holds full high.
// CSR writes are taken throughout; histogram_enable resets to 1.
`timescale 1ns / 1ps
module pulse_height_histogram_engine import phh_pkg::*; #(
   parameter int BIN_COUNT   = BIN_COUNT_DEF,
   parameter int COUNT_WIDTH = COUNT_WIDTH_DEF
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        push,
   output logic        full,
   input  req_type     req_payload,
   output logic        empty,
   input  logic        pop,
   output rsp_type     rsp_payload,
   input  logic        psel,
   input  logic        penable,
   input  logic        pwrite,
   input  logic [1:0]  paddr,
   input  logic [31:0] pwdata,
   output logic [31:0] prdata,
   output logic        pready
);

   localparam int ADDR_W = $clog2(BIN_COUNT);

   logic              hist_en_ff;
   logic              csr_we;
   logic              init_busy;
   logic              op_valid, op_take, op_rd_ok;
   cmd_type           op_cmd;
   logic [ADDR_W-1:0] op_addr;
   logic [CODE_W-1:0] op_code;

   assign pready = 1'b1;
   assign csr_we = psel && penable && pwrite && pready && (paddr == REG_HIST_EN);
   assign prdata = (paddr == REG_HIST_EN) ? {31'b0, hist_en_ff} : '0;

   always_ff @(posedge clock) begin
      if (reset) begin
         hist_en_ff <= 1'b1;
      end else if (csr_we) begin
         hist_en_ff <= pwdata[0];
      end
   end

   phh_front #(
      .BIN_COUNT (BIN_COUNT)
   ) u_front (
      .clock       (clock),
      .reset       (reset),
      .push        (push),
      .full        (full),
      .req_payload (req_payload),
      .init_busy   (init_busy),
      .op_valid    (op_valid),
      .op_cmd      (op_cmd),
      .op_addr     (op_addr),
      .op_rd_ok    (op_rd_ok),
      .op_code     (op_code),
      .op_take     (op_take)
   );

   phh_back #(
      .BIN_COUNT   (BIN_COUNT),
      .COUNT_WIDTH (COUNT_WIDTH)
   ) u_back (
      .clock     (clock),
      .reset     (reset),
      .hist_en   (hist_en_ff),
      .op_valid  (op_valid),
      .op_cmd    (op_cmd),
      .op_addr   (op_addr),
      .op_rd_ok  (op_rd_ok),
      .op_code   (op_code),
      .op_take   (op_take),
      .init_busy (init_busy),
      .rsp_empty (empty),
      .rsp_pop   (pop),
      .rsp_data  (rsp_payload)
   );

endmodule

/* hw/rtl/phh_checker.sv */
// Port-level checks for the pulse-height histogram engine, bound to the top level.
`timescale 1ns / 1ps
module phh_checker import phh_pkg::*; (
   input logic    clock,
   input logic    reset,
   input logic    full,
   input logic    empty,
   input logic    pop,
   input rsp_type rsp_payload
);

   a_reset_quiet: assert property (@(posedge clock)
      reset |=> full && empty)
      else $error("queue not held full and empty after reset");

   a_full_scale_peak: assert property (@(posedge clock) disable iff (reset)
      (!empty && rsp_payload.full_scale_count != '0) |->
         rsp_payload.peak_code == FULL_SCALE_CODE)
      else $error("full-scale count without full-scale peak");

   a_rsp_held: assert property (@(posedge clock) disable iff (reset)
      (!empty && !pop) |=> !empty)
      else $error("result dropped without transfer");

   a_rsp_stable: assert property (@(posedge clock) disable iff (reset)
      (!empty && !pop) |=> $stable(rsp_payload))
      else $error("result changed while waiting");

endmodule

bind pulse_height_histogram_engine phh_checker u_phh_checker (.*);
